// ----- sv/hlp_pkg.sv -----
// ----------------------------------------------------------------------------
// hlp_pkg
// Shared types and codes of the linear-probing hash table.
// ----------------------------------------------------------------------------
package hlp_pkg;

    localparam int KEY_W = 64;
    localparam int TS_W  = 7;
    localparam int CNT_W = 7;
    localparam int SUM_W = 11;

    localparam logic [TS_W-1:0] TS_RESET = 7'd64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_NO_FREE   = 3'd2;
    localparam logic [2:0] STAT_FOUND     = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [2:0] STAT_REMOVED   = 3'd5;

    localparam logic ADDR_TABLE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_LIVE    = 2'd1,
        TAG_DELETED = 2'd2
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [KEY_W-1:0]  key;
    } t_row;

    typedef struct packed {
        logic              done;
        logic [TS_W-1:0]   rem;
    } t_mod_res;

endpackage

// ----- sv/hash_table_linear_probe_core.sv -----
// ----------------------------------------------------------------------------
// hash_table_linear_probe_core
// Open-addressing hash table with linear probing and deleted markers.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream: tuser carries the command (insert,
// search, remove), tdata the key. Results leave on the m_ stream: tuser
// carries the status, tdata the slot index, probe count and live count.
// The table size register is written over the APB port. The user is to
// write it only while idle; the block itself does not enforce this.
// One command at a time: o_s_tready is high only while the block is idle.
// The command is taken, the remainder unit computes the home slot, then
// the probe loop examines one slot per cycle (up to the table size), and
// the result register is loaded. Commands rejected as full, and unknown
// commands, skip the remainder unit and probes.
// The probe loop through the slot memory's single read port sets the rate.
// A result waits in the output register while the receiver stalls; a new
// command is not taken until that result has been loaded.
// Reset clears all slot tags (valid bits), the live count, and sets the
// table size to 64.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_core
    import hlp_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command transfer
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] key
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    // result transfer
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [5:0] slot_index, [12:6] probe_count,
                                     // [19:13] occupied, [23:20] zero
    output logic [2:0]  o_m_tuser,   // [2:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MEM_DEPTH = (SLOTS < 128) ? SLOTS : 128;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SIZE_CAP  = (SLOTS < 127) ? SLOTS : 127;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_FIN
    } t_state;

    t_state           r_state;
    logic [TS_W-1:0]  r_table_size;
    logic [CNT_W-1:0] r_live;
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [TS_W-1:0]  r_size;
    logic [AW-1:0]    r_idx;
    logic [CNT_W-1:0] r_probe;
    logic [2:0]       r_res_status;
    logic [TS_W-1:0]  r_res_slot;
    logic [CNT_W-1:0] r_res_probes;
    logic             r_out_valid;
    logic [2:0]       r_out_status;
    logic [5:0]       r_out_slot;
    logic [CNT_W-1:0] r_out_probes;
    logic [CNT_W-1:0] r_out_live;

    logic             n_accept;
    logic             n_cfg_wr;
    logic [TS_W-1:0]  n_size;
    logic [SUM_W-1:0] n_sum;
    logic             n_mod_start;
    t_mod_res         n_mod;
    logic [AW:0]      n_inc;
    logic [AW-1:0]    n_next_idx;
    logic [AW-1:0]    n_rd_addr;
    logic             n_wr_en;
    t_row             n_wr_row;
    t_row             n_rd_row;
    logic [CNT_W-1:0] n_examined;
    logic             n_last;
    logic             n_hit;
    logic             n_load;

    assign pready     = 1'b1;
    assign n_cfg_wr   = psel && penable && pwrite && (paddr[2] == ADDR_TABLE_SIZE);
    assign prdata     = (paddr[2] == ADDR_TABLE_SIZE) ? {25'd0, r_table_size} : 32'd0;
    assign o_s_tready = (r_state == ST_IDLE);
    assign n_accept   = i_s_tvalid && o_s_tready;
    assign n_load     = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);

    always_comb begin
        if (r_table_size == '0) begin
            n_size = 7'd1;
        end else if (32'(r_table_size) > SIZE_CAP) begin
            n_size = 7'(SIZE_CAP);
        end else begin
            n_size = r_table_size;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            n_sum = n_sum + SUM_W'(i_s_tdata[8*b +: 8]);
        end
    end

    assign n_mod_start = n_accept
        && (i_s_tuser == CMD_SEARCH || i_s_tuser == CMD_REMOVE
            || (i_s_tuser == CMD_INSERT && r_live < n_size));

    hlp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_mod_start),
        .i_dividend (n_sum),
        .i_divisor  (n_size),
        .o_res      (n_mod)
    );

    assign n_inc      = {1'b0, r_idx} + (AW+1)'(1);
    assign n_next_idx = (32'(n_inc) == 32'(r_size)) ? '0 : n_inc[AW-1:0];
    assign n_rd_addr  = (r_state == ST_MOD) ? AW'(n_mod.rem) : n_next_idx;
    assign n_examined = r_probe + CNT_W'(1);
    assign n_last     = (n_examined == r_size);
    assign n_hit      = (n_rd_row.tag == TAG_LIVE) && (n_rd_row.key == r_key);

    always_comb begin
        n_wr_en      = 1'b0;
        n_wr_row.tag = TAG_LIVE;
        n_wr_row.key = r_key;
        if (r_state == ST_PROBE) begin
            if (r_cmd == CMD_INSERT) begin
                n_wr_en = (n_rd_row.tag != TAG_LIVE);
            end else if (r_cmd == CMD_REMOVE) begin
                n_wr_en      = n_hit;
                n_wr_row.tag = TAG_DELETED;
            end
        end
    end

    hlp_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_row  (n_wr_row),
        .i_rd_addr (n_rd_addr),
        .o_rd_row  (n_rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_table_size <= TS_RESET;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (n_cfg_wr) begin
                r_table_size <= pwdata[TS_W-1:0];
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_cmd        <= i_s_tuser;
                        r_key        <= i_s_tdata & KEY_MASK;
                        r_size       <= n_size;
                        r_res_slot   <= '0;
                        r_res_probes <= '0;
                        if (n_mod_start) begin
                            r_res_status <= STAT_NOT_FOUND;
                            r_state      <= ST_MOD;
                        end else begin
                            r_res_status <= (i_s_tuser == CMD_INSERT) ? STAT_FULL
                                                                       : STAT_NOT_FOUND;
                            r_state      <= ST_FIN;
                        end
                    end
                end
                ST_MOD: begin
                    if (n_mod.done) begin
                        r_idx   <= AW'(n_mod.rem);
                        r_probe <= '0;
                        r_state <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    r_idx   <= n_next_idx;
                    r_probe <= n_examined;
                    if (r_cmd == CMD_INSERT) begin
                        if (n_rd_row.tag != TAG_LIVE) begin
                            r_live       <= r_live + CNT_W'(1);
                            r_res_status <= STAT_INSERTED;
                            r_res_slot   <= TS_W'(r_idx);
                            r_res_probes <= n_examined;
                            r_state      <= ST_FIN;
                        end else if (n_last) begin
                            r_res_status <= STAT_NO_FREE;
                            r_res_probes <= n_examined;
                            r_state      <= ST_FIN;
                        end
                    end else begin
                        if (n_hit) begin
                            if (r_cmd == CMD_REMOVE) begin
                                r_res_status <= STAT_REMOVED;
                                if (r_live != '0) begin
                                    r_live <= r_live - CNT_W'(1);
                                end
                            end else begin
                                r_res_status <= STAT_FOUND;
                            end
                            r_res_slot   <= TS_W'(r_idx);
                            r_res_probes <= n_examined;
                            r_state      <= ST_FIN;
                        end else if (n_rd_row.tag == TAG_EMPTY || n_last) begin
                            r_res_probes <= n_examined;
                            r_state      <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (n_load) begin
                        r_out_status <= r_res_status;
                        r_out_slot   <= r_res_slot[5:0];
                        r_out_probes <= r_res_probes;
                        r_out_live   <= r_live;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {4'd0, r_out_live, r_out_probes, r_out_slot};

    a_live_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= SIZE_CAP)
        else $error("live count above the largest table size");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_probe < r_size && 32'(r_idx) < 32'(r_size)))
        else $error("probe outside the table in use");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE && r_cmd == CMD_INSERT) |-> (r_live < r_size))
        else $error("insert probing a table already full");

    a_fin_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && !i_m_tready) |=> (r_state == ST_FIN))
        else $error("result dropped while receiver stalls");

endmodule

// ----- sv/hlp_mod.sv -----
// ----------------------------------------------------------------------------
// hlp_mod
// Iterative remainder unit: one restoring subtract step per cycle.
// ----------------------------------------------------------------------------
module hlp_mod
    import hlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [TS_W-1:0]  i_divisor,
    output t_mod_res         o_res
);

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_cnt;
    logic [SUM_W-1:0] r_dvd;
    logic [TS_W-1:0]  r_div;
    logic [TS_W-1:0]  r_rem;
    logic [TS_W:0]    n_trial;
    logic [TS_W:0]    n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[SUM_W-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem = n_trial - {1'b0, r_div};
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 4'(SUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem[TS_W-1:0];
                r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still busy");

endmodule

// ----- sv/hlp_ram.sv -----
// ----------------------------------------------------------------------------
// hlp_ram
// Slot store: key and tag per row, registered read, per-row valid bits.
// ----------------------------------------------------------------------------
module hlp_ram
    import hlp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_row          i_wr_row,
    input  logic [AW-1:0] i_rd_addr,
    output t_row          o_rd_row
);

    t_row             r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_row             r_rd_row;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        r_rd_row <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_comb begin
        o_rd_row = r_rd_row;
        if (!r_rd_valid) begin
            o_rd_row.tag = TAG_EMPTY;
        end
    end

endmodule
